// ===== hw/rtl/fbe_pkg.sv =====
// Shared types and codes for the fault budget escalation block.
// Holds the item, result, configuration and counter control structures.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package fbe_pkg;

   localparam int unsigned LIMIT_WIDTH = 32;
   localparam int unsigned OBS_WIDTH   = 32;

   localparam logic [2:0] CLS_BOOTSTRAP = 3'd0;
   localparam logic [2:0] CLS_MODULE    = 3'd1;
   localparam logic [2:0] CLS_EVENT     = 3'd2;
   localparam logic [2:0] CLS_RENDER    = 3'd3;
   localparam logic [2:0] CLS_TIMING    = 3'd4;
   localparam logic [2:0] CLS_SHUTDOWN  = 3'd5;

   localparam int unsigned FLAG_DETERMINISTIC = 0;
   localparam int unsigned FLAG_RENDERING     = 1;
   localparam int unsigned FLAG_TIMING_FAIL   = 2;

   typedef enum logic [2:0] {
      CSR_ENABLED        = 3'd0,
      CSR_POLICY_FLAGS   = 3'd1,
      CSR_MODULE_LIMIT   = 3'd2,
      CSR_EVENT_LIMIT    = 3'd3,
      CSR_RENDER_LIMIT   = 3'd4,
      CSR_TIMING_LIMIT   = 3'd5,
      CSR_SHUTDOWN_LIMIT = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      RSN_NOT_ENABLED     = 5'd0,
      RSN_BREACH          = 5'd1,
      RSN_DETERMINISTIC   = 5'd2,
      RSN_BOOTSTRAP       = 5'd3,
      RSN_MODULE_FAIL     = 5'd4,
      RSN_MODULE_DEGRADED = 5'd5,
      RSN_MODULE_EXCEEDED = 5'd6,
      RSN_EVENT_VIOLATION = 5'd7,
      RSN_EVENT_DEGRADED  = 5'd8,
      RSN_EVENT_EXCEEDED  = 5'd9,
      RSN_RENDER_DISABLED = 5'd10,
      RSN_RENDER_VIOLATION = 5'd11,
      RSN_RENDER_DEGRADED = 5'd12,
      RSN_RENDER_EXCEEDED = 5'd13,
      RSN_TIMING_FAIL     = 5'd14,
      RSN_TIMING_DEGRADED = 5'd15,
      RSN_TIMING_EXCEEDED = 5'd16,
      RSN_SHUTDOWN_FAIL   = 5'd17,
      RSN_SHUTDOWN_DEGRADED = 5'd18,
      RSN_SHUTDOWN_EXCEEDED = 5'd19,
      RSN_UNKNOWN_CLASS   = 5'd20,
      RSN_CLEARED         = 5'd21
   } reason_type;

   typedef struct packed {
      logic       command;
      logic [2:0] report_class;
      logic       breach;
      logic       mod_required;
      logic       violation;
      logic       fatal_shutdown;
   } item_type;

   typedef struct packed {
      logic                   disposition;
      logic                   escalated;
      logic                   budget_used;
      logic [OBS_WIDTH-1:0]   class_count;
      reason_type             reason_code;
   } result_type;

   typedef struct packed {
      logic                   enabled;
      logic [2:0]             policy_flags;
      logic [LIMIT_WIDTH-1:0] module_limit;
      logic [LIMIT_WIDTH-1:0] event_limit;
      logic [LIMIT_WIDTH-1:0] render_limit;
      logic [LIMIT_WIDTH-1:0] timing_limit;
      logic [LIMIT_WIDTH-1:0] shutdown_limit;
   } config_type;

   typedef struct packed {
      logic bump;
      logic clear;
   } count_ctrl_type;

endpackage

// ===== hw/rtl/fbe_count_bank.sv =====
// Per-class occurrence counters with saturating increment and clear.
// Presents the bumped value of the selected class for the decision logic.
// Depends on fbe_pkg for the counter control structure.
`timescale 1ns / 1ps

module fbe_count_bank #(
   parameter int unsigned NUM_CLASSES = 6,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [2:0]                 rd_class,
   input  fbe_pkg::count_ctrl_type    ctrl,
   output logic                       in_range,
   output logic [COUNT_WIDTH-1:0]     bump_value
);

   localparam int unsigned IDX_W = $clog2(NUM_CLASSES);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] counts_ff [NUM_CLASSES];
   logic [COUNT_WIDTH-1:0] current;
   logic [IDX_W-1:0]       idx;

   assign in_range = (32'(rd_class) < NUM_CLASSES);
   assign idx      = IDX_W'(rd_class);

   always_comb begin
      current = '0;
      if (in_range) begin
         current = counts_ff[idx];
      end
      if (!in_range) begin
         bump_value = '0;
      end else if (current == CNT_MAX) begin
         bump_value = current;
      end else begin
         bump_value = current + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (ctrl.bump && in_range) begin
         counts_ff[idx] <= bump_value;
      end
   end

endmodule

// ===== hw/rtl/fbe_policy.sv =====
// Decision logic: fail-fast or degrade, escalation and reason code per report.
// Pure combinational; takes the bumped class count from fbe_count_bank.
// Depends on fbe_pkg for item, result, configuration and control types.
`timescale 1ns / 1ps

module fbe_policy #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  fbe_pkg::item_type          item,
   input  fbe_pkg::config_type        cfg,
   input  logic                       in_range,
   input  logic [COUNT_WIDTH-1:0]     bump_value,
   output fbe_pkg::result_type        result,
   output fbe_pkg::count_ctrl_type    ctrl
);

   logic [fbe_pkg::LIMIT_WIDTH-1:0] limit;
   logic [fbe_pkg::OBS_WIDTH-1:0]   n_obs;
   logic                            budgeted;
   fbe_pkg::reason_type             ok_reason;
   fbe_pkg::reason_type             esc_reason;

   assign n_obs = fbe_pkg::OBS_WIDTH'(bump_value);

   always_comb begin
      result     = '0;
      ctrl       = '0;
      limit      = '0;
      budgeted   = 1'b0;
      ok_reason  = fbe_pkg::RSN_NOT_ENABLED;
      esc_reason = fbe_pkg::RSN_NOT_ENABLED;
      result.reason_code = fbe_pkg::RSN_NOT_ENABLED;

      if (item.command) begin
         ctrl.clear = 1'b1;
         result.reason_code = fbe_pkg::RSN_CLEARED;
      end else if (cfg.enabled) begin
         ctrl.bump = in_range;
         result.class_count = n_obs;
         if (item.breach) begin
            result.reason_code = fbe_pkg::RSN_BREACH;
         end else if (cfg.policy_flags[fbe_pkg::FLAG_DETERMINISTIC]) begin
            result.reason_code = fbe_pkg::RSN_DETERMINISTIC;
         end else begin
            case (item.report_class)
               fbe_pkg::CLS_BOOTSTRAP: begin
                  result.reason_code = fbe_pkg::RSN_BOOTSTRAP;
               end
               fbe_pkg::CLS_MODULE: begin
                  if (item.mod_required || item.violation) begin
                     result.reason_code = fbe_pkg::RSN_MODULE_FAIL;
                  end else begin
                     budgeted   = 1'b1;
                     limit      = cfg.module_limit;
                     ok_reason  = fbe_pkg::RSN_MODULE_DEGRADED;
                     esc_reason = fbe_pkg::RSN_MODULE_EXCEEDED;
                  end
               end
               fbe_pkg::CLS_EVENT: begin
                  if (item.violation) begin
                     result.reason_code = fbe_pkg::RSN_EVENT_VIOLATION;
                  end else begin
                     budgeted   = 1'b1;
                     limit      = cfg.event_limit;
                     ok_reason  = fbe_pkg::RSN_EVENT_DEGRADED;
                     esc_reason = fbe_pkg::RSN_EVENT_EXCEEDED;
                  end
               end
               fbe_pkg::CLS_RENDER: begin
                  if (!cfg.policy_flags[fbe_pkg::FLAG_RENDERING]) begin
                     result.reason_code = fbe_pkg::RSN_RENDER_DISABLED;
                  end else if (item.violation) begin
                     result.reason_code = fbe_pkg::RSN_RENDER_VIOLATION;
                  end else begin
                     budgeted   = 1'b1;
                     limit      = cfg.render_limit;
                     ok_reason  = fbe_pkg::RSN_RENDER_DEGRADED;
                     esc_reason = fbe_pkg::RSN_RENDER_EXCEEDED;
                  end
               end
               fbe_pkg::CLS_TIMING: begin
                  if (cfg.policy_flags[fbe_pkg::FLAG_TIMING_FAIL] ||
                      item.violation) begin
                     result.reason_code = fbe_pkg::RSN_TIMING_FAIL;
                  end else begin
                     budgeted   = 1'b1;
                     limit      = cfg.timing_limit;
                     ok_reason  = fbe_pkg::RSN_TIMING_DEGRADED;
                     esc_reason = fbe_pkg::RSN_TIMING_EXCEEDED;
                  end
               end
               fbe_pkg::CLS_SHUTDOWN: begin
                  if (item.fatal_shutdown || item.violation) begin
                     result.reason_code = fbe_pkg::RSN_SHUTDOWN_FAIL;
                  end else begin
                     budgeted   = 1'b1;
                     limit      = cfg.shutdown_limit;
                     ok_reason  = fbe_pkg::RSN_SHUTDOWN_DEGRADED;
                     esc_reason = fbe_pkg::RSN_SHUTDOWN_EXCEEDED;
                  end
               end
               default: begin
                  result.reason_code = fbe_pkg::RSN_UNKNOWN_CLASS;
               end
            endcase
         end

         if (budgeted) begin
            if ((limit == '0) || (n_obs > limit)) begin
               result.escalated   = 1'b1;
               result.reason_code = esc_reason;
            end else begin
               result.disposition = 1'b1;
               result.budget_used = 1'b1;
               result.reason_code = ok_reason;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/fault_budget_escalation.sv =====
// Words pass the stage-one item register, then the result register. Throughput: one
// word per cycle unless rsp_tready stalls; the class counter read, increment and write
// complete in the same cycle, so reports of the same class may follow back to back.
// Reset is synchronous and active high: it clears the configuration registers,
// all class counters and both valid flags. No clearing pass is needed.
`timescale 1ns / 1ps

module fault_budget_escalation #(
   parameter int unsigned NUM_CLASSES = 6,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // report_class[2:0], breach[3], mod_required[4],
   // violation[5], fatal_shutdown[6], zero[7]
   input  logic [7:0]  req_tdata,
   // command[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // disposition[0], escalated[1], budget_used[2],
   // class_count[34:3], reason_code[39:35]
   output logic [39:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   fbe_pkg::config_type     cfg_ff, cfg_in;
   fbe_pkg::item_type       s1_item_ff, req_item;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fbe_pkg::result_type     rsp_data_ff, result;
   fbe_pkg::count_ctrl_type pol_ctrl, bank_ctrl;
   logic                    in_range;
   logic [COUNT_WIDTH-1:0]  bump_value;
   logic                    advance;
   logic                    req_accept;
   logic                    csr_clear;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign req_item.command        = req_tuser;
   assign req_item.report_class   = req_tdata[2:0];
   assign req_item.breach         = req_tdata[3];
   assign req_item.mod_required   = req_tdata[4];
   assign req_item.violation      = req_tdata[5];
   assign req_item.fatal_shutdown = req_tdata[6];

   always_comb begin
      cfg_in    = cfg_ff;
      csr_clear = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            fbe_pkg::CSR_ENABLED: begin
               cfg_in.enabled = csr_wdata[0];
               csr_clear      = 1'b1;
            end
            fbe_pkg::CSR_POLICY_FLAGS:   cfg_in.policy_flags   = csr_wdata[2:0];
            fbe_pkg::CSR_MODULE_LIMIT:   cfg_in.module_limit   = csr_wdata;
            fbe_pkg::CSR_EVENT_LIMIT:    cfg_in.event_limit    = csr_wdata;
            fbe_pkg::CSR_RENDER_LIMIT:   cfg_in.render_limit   = csr_wdata;
            fbe_pkg::CSR_TIMING_LIMIT:   cfg_in.timing_limit   = csr_wdata;
            fbe_pkg::CSR_SHUTDOWN_LIMIT: cfg_in.shutdown_limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= result;
      end
   end

   fbe_count_bank #(
      .NUM_CLASSES (NUM_CLASSES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_count_bank (
      .clock      (clock),
      .reset      (reset),
      .rd_class   (s1_item_ff.report_class),
      .ctrl       (bank_ctrl),
      .in_range   (in_range),
      .bump_value (bump_value)
   );

   fbe_policy #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_policy (
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .in_range   (in_range),
      .bump_value (bump_value),
      .result     (result),
      .ctrl       (pol_ctrl)
   );

   assign bank_ctrl.bump  = pol_ctrl.bump && s1_valid_ff && advance;
   assign bank_ctrl.clear = (pol_ctrl.clear && s1_valid_ff && advance) || csr_clear;

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata[0]     = rsp_data_ff.disposition;
   assign rsp_tdata[1]     = rsp_data_ff.escalated;
   assign rsp_tdata[2]     = rsp_data_ff.budget_used;
   assign rsp_tdata[34:3]  = rsp_data_ff.class_count;
   assign rsp_tdata[39:35] = rsp_data_ff.reason_code;

   // A degrade always consumes budget and is never an escalation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == rsp_tdata[2]) && !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("degrade word with inconsistent budget flags");

   // A cleared-counters word reports fail fast with no count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[39:35] == fbe_pkg::RSN_CLEARED)) |->
      ((rsp_tdata[34:3] == '0) && (rsp_tdata[2:0] == 3'b000)))
      else $error("clear word carries a count or decision");

   // With the result register empty the block must take a new word.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stalled with an empty result register");

   // A word held in the result register keeps the counters untouched.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !bank_ctrl.bump)
      else $error("counter bumped while the pipeline was stalled");

endmodule
